[design/hsv_pkg.sv]
// Shared types and constants for the HSV to RGB converter.
// Used by hsv_front, hsv_queue, hsv_back and the top level; no dependencies.
`timescale 1ns / 1ps

package hsv_pkg;

    // Input field widths
    localparam int HUE_W = 9;
    localparam int PCT_W = 7;
    localparam int CH_W  = 8;

    // Hue sector codes (hexcone sides of 60 degrees)
    localparam logic [2:0] SEC_0 = 3'd0;
    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;
    localparam logic [2:0] SEC_5 = 3'd5;

    // Full hue wrap and percent ceiling
    localparam logic [HUE_W-1:0] HUE_WRAP = 9'd360;
    localparam logic [PCT_W-1:0] PCT_MAX  = 7'd100;

    // Weight of a full channel: 100 percent times 60 degrees
    localparam logic [12:0] K_FULL = 13'd6000;

    // Division by 600000 = 64 * 9375; 9375 by reciprocal multiply.
    // Exact for the 22-bit quotient input since M * (C*9375 - 2^36) < 2^36.
    localparam int          DIV_SHIFT = 6;
    localparam int          RECIP_K   = 36;
    localparam logic [22:0] RECIP_C   = 23'd7330078;

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Classified item passed from front to back
    typedef struct packed {
        logic [2:0]       sector;
        logic [5:0]       rem;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] val;
    } t_cls;

endpackage

[design/hsv_front.sv]
// Front stage: accepts an input item, wraps and splits the hue, clamps percents.
// Depends on hsv_pkg.
`timescale 1ns / 1ps

module hsv_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [hsv_pkg::HUE_W-1:0] i_hue,
    input  logic [hsv_pkg::PCT_W-1:0] i_saturation,
    input  logic [hsv_pkg::PCT_W-1:0] i_brightness,
    output logic                      o_push,
    output hsv_pkg::t_cls             o_cls,
    input  logic                      i_full
);

    logic                      r_fv;
    logic                      n_fv;
    hsv_pkg::t_cls             r_cls;
    hsv_pkg::t_cls             n_cls;
    logic [hsv_pkg::HUE_W-1:0] w_hue;
    logic                      w_take;

    // Hold the item while the queue is full
    assign o_stall = r_fv && i_full;
    assign o_push  = r_fv && !i_full;
    assign w_take  = i_valid && !o_stall;
    assign o_cls   = r_cls;

    // Wrap hue once, find sector and remainder, clamp percents
    always_comb begin
        w_hue = (i_hue >= hsv_pkg::HUE_WRAP) ? (i_hue - hsv_pkg::HUE_WRAP) : i_hue;
        if (w_hue >= 9'd300) begin
            n_cls.sector = hsv_pkg::SEC_5;
            n_cls.rem    = 6'(w_hue - 9'd300);
        end else if (w_hue >= 9'd240) begin
            n_cls.sector = hsv_pkg::SEC_4;
            n_cls.rem    = 6'(w_hue - 9'd240);
        end else if (w_hue >= 9'd180) begin
            n_cls.sector = hsv_pkg::SEC_3;
            n_cls.rem    = 6'(w_hue - 9'd180);
        end else if (w_hue >= 9'd120) begin
            n_cls.sector = hsv_pkg::SEC_2;
            n_cls.rem    = 6'(w_hue - 9'd120);
        end else if (w_hue >= 9'd60) begin
            n_cls.sector = hsv_pkg::SEC_1;
            n_cls.rem    = 6'(w_hue - 9'd60);
        end else begin
            n_cls.sector = hsv_pkg::SEC_0;
            n_cls.rem    = 6'(w_hue);
        end
        n_cls.sat = (i_saturation > hsv_pkg::PCT_MAX) ? hsv_pkg::PCT_MAX : i_saturation;
        n_cls.val = (i_brightness > hsv_pkg::PCT_MAX) ? hsv_pkg::PCT_MAX : i_brightness;
    end

    // Occupancy: fill on accept, drain on push
    always_comb begin
        n_fv = r_fv;
        if (w_take) begin
            n_fv = 1'b1;
        end else if (o_push) begin
            n_fv = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= n_fv;
        end
    end

    // Capture payload on accept
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cls <= n_cls;
        end
    end

endmodule

[design/hsv_queue.sv]
// Short FIFO of classified items between front and back.
// Depends on hsv_pkg.
`timescale 1ns / 1ps

module hsv_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hsv_pkg::t_cls i_cls,
    input  logic          i_pop,
    output hsv_pkg::t_cls o_cls,
    output logic          o_full,
    output logic          o_empty
);

    hsv_pkg::t_cls            r_mem [hsv_pkg::Q_DEPTH];
    logic [hsv_pkg::Q_AW-1:0] r_wp;
    logic [hsv_pkg::Q_AW-1:0] r_rp;
    logic [hsv_pkg::Q_CW-1:0] r_cnt;
    logic [hsv_pkg::Q_AW-1:0] n_wp;
    logic [hsv_pkg::Q_AW-1:0] n_rp;
    logic [hsv_pkg::Q_CW-1:0] n_cnt;

    localparam logic [hsv_pkg::Q_AW-1:0] LAST = hsv_pkg::Q_AW'(hsv_pkg::Q_DEPTH - 1);
    localparam logic [hsv_pkg::Q_CW-1:0] FULL = hsv_pkg::Q_CW'(hsv_pkg::Q_DEPTH);

    assign o_full  = (r_cnt == FULL);
    assign o_empty = (r_cnt == '0);
    assign o_cls   = r_mem[r_rp];

    // Advance pointers and count
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == LAST) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == LAST) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cls;
        end
    end

    // Queue never overflows or underflows, and count stays in range
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> !o_full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL)
        else $error("queue count out of range");

endmodule

[design/hsv_back.sv]
// Back pipeline: per-channel weights, scale by v*255, divide by 600000.
// Depends on hsv_pkg.
`timescale 1ns / 1ps

module hsv_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  hsv_pkg::t_cls            i_cls,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [hsv_pkg::CH_W-1:0] o_red,
    output logic [hsv_pkg::CH_W-1:0] o_green,
    output logic [hsv_pkg::CH_W-1:0] o_blue
);

    // Stage valids
    logic        r_v1, r_v2, r_v3, r_v4;
    logic        w_en;

    // Stage 1: partial weights
    logic [2:0]  r_sec1;
    logic [12:0] r_sr1;
    logic [12:0] r_bk1;
    logic [14:0] r_vv1;

    // Stage 2: channel weights
    logic [12:0] r_k2 [3];
    logic [12:0] n_k2 [3];
    logic [14:0] r_vv2;
    logic [12:0] w_up;
    logic [12:0] w_dn;

    // Stage 3: scaled numerators over 64
    logic [21:0] r_m3 [3];
    logic [27:0] w_n3 [3];

    // Stage 4: reciprocal products
    logic [44:0] r_p4 [3];

    // Move the whole pipe unless the result is held
    assign w_en    = !(r_v4 && i_stall);
    assign o_pop   = w_en && i_valid;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Pick weight per channel by hexcone side
    always_comb begin
        w_up = r_bk1 + r_sr1;
        w_dn = hsv_pkg::K_FULL - r_sr1;
        unique case (r_sec1)
            hsv_pkg::SEC_0: begin
                n_k2[0] = hsv_pkg::K_FULL; n_k2[1] = w_up;           n_k2[2] = r_bk1;
            end
            hsv_pkg::SEC_1: begin
                n_k2[0] = w_dn;           n_k2[1] = hsv_pkg::K_FULL; n_k2[2] = r_bk1;
            end
            hsv_pkg::SEC_2: begin
                n_k2[0] = r_bk1;          n_k2[1] = hsv_pkg::K_FULL; n_k2[2] = w_up;
            end
            hsv_pkg::SEC_3: begin
                n_k2[0] = r_bk1;          n_k2[1] = w_dn;           n_k2[2] = hsv_pkg::K_FULL;
            end
            hsv_pkg::SEC_4: begin
                n_k2[0] = w_up;           n_k2[1] = r_bk1;          n_k2[2] = hsv_pkg::K_FULL;
            end
            default: begin
                n_k2[0] = hsv_pkg::K_FULL; n_k2[1] = r_bk1;          n_k2[2] = w_dn;
            end
        endcase
    end

    // Scale each weight by v*255
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_n3[i] = 28'(r_vv2) * 28'(r_k2[i]);
        end
    end

    // Payload registers advance with the pipe
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sec1 <= i_cls.sector;
            r_sr1  <= 13'(i_cls.rem) * 13'(i_cls.sat);
            r_bk1  <= 13'(hsv_pkg::PCT_MAX - i_cls.sat) * 13'd60;
            r_vv1  <= 15'(i_cls.val) * 15'd255;
            r_vv2  <= r_vv1;
            for (int i = 0; i < 3; i++) begin
                r_k2[i] <= n_k2[i];
                r_m3[i] <= w_n3[i][27:hsv_pkg::DIV_SHIFT];
                r_p4[i] <= 45'(r_m3[i]) * 45'(hsv_pkg::RECIP_C);
            end
        end
    end

    assign o_red   = r_p4[0][hsv_pkg::RECIP_K+hsv_pkg::CH_W-1:hsv_pkg::RECIP_K];
    assign o_green = r_p4[1][hsv_pkg::RECIP_K+hsv_pkg::CH_W-1:hsv_pkg::RECIP_K];
    assign o_blue  = r_p4[2][hsv_pkg::RECIP_K+hsv_pkg::CH_W-1:hsv_pkg::RECIP_K];

    // Weights never exceed a full channel; a held result keeps the pipe frozen
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_k2[0] <= hsv_pkg::K_FULL) && (r_k2[1] <= hsv_pkg::K_FULL)
                 && (r_k2[2] <= hsv_pkg::K_FULL))
        else $error("channel weight out of range");
    a_quot_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_p4[0][44] == 1'b0) && (r_p4[1][44] == 1'b0) && (r_p4[2][44] == 1'b0))
        else $error("quotient overflow");
    a_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && i_stall |=> r_v4 && $stable(r_v3) && !$past(o_pop))
        else $error("pipe moved while result held");

endmodule

[design/hsv_to_rgb_converter.sv]
// Top level of the HSV to RGB converter: front, queue and back pipeline.
// Depends on hsv_pkg, hsv_front, hsv_queue, hsv_back.
//
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+-------------------------------------------
//  input    | i_valid  | o_stall  | i_hue[8:0], i_saturation[6:0], i_brightness[6:0]
//  output   | o_valid  | i_stall  | o_red[7:0], o_green[7:0], o_blue[7:0]
//
// One item per cycle sustained while i_stall is low. An accepted item loads the front
// register at the accepting edge, then passes the queue and four back stages
// before o_valid rises.
// Reset is synchronous and active low; no state survives an item.
// An output stall freezes the back pipe while a result is held; the two-entry
// queue and front register keep taking items until they fill, then o_stall rises.
`timescale 1ns / 1ps

module hsv_to_rgb_converter (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [hsv_pkg::HUE_W-1:0] i_hue,
    input  logic [hsv_pkg::PCT_W-1:0] i_saturation,
    input  logic [hsv_pkg::PCT_W-1:0] i_brightness,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [hsv_pkg::CH_W-1:0]  o_red,
    output logic [hsv_pkg::CH_W-1:0]  o_green,
    output logic [hsv_pkg::CH_W-1:0]  o_blue
);

    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;
    hsv_pkg::t_cls w_fcls;
    hsv_pkg::t_cls w_qcls;

    // Accept and classify
    hsv_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_push       (w_push),
        .o_cls        (w_fcls),
        .i_full       (w_full)
    );

    // Decouple front from back
    hsv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cls   (w_fcls),
        .i_pop   (w_pop),
        .o_cls   (w_qcls),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // Compute channels
    hsv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!w_empty),
        .i_cls   (w_qcls),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

endmodule
